FILE: rtl/rvr_pkg.sv
package rvr_pkg;

    localparam int CW          = 16;   // component width, Q4.12
    localparam int AW          = 16;   // angle width, Q3.13
    localparam int UW          = 18;   // unit axis component, signed Q16
    localparam int TW          = 18;   // sine and cosine, signed Q16
    localparam int ZW          = 34;   // CORDIC datapath width, Q30
    localparam int EPS_W       = 12;
    localparam int CORDIC_STAGES_DEFAULT = 16;

    localparam logic [EPS_W-1:0] EPS_RESET = 12'd1;
    localparam logic signed [AW-1:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [AW-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic signed [AW-1:0] angle_t;
    typedef logic signed [UW-1:0] unit_t;
    typedef logic signed [TW-1:0] trig_t;

    typedef struct packed {
        comp_t  vec_x;
        comp_t  vec_y;
        comp_t  vec_z;
        comp_t  axis_x;
        comp_t  axis_y;
        comp_t  axis_z;
        angle_t angle;
    } in_t;

    typedef struct packed {
        comp_t rot_x;
        comp_t rot_y;
        comp_t rot_z;
        logic  axis_was_zero;
        logic  saturated;
    } out_t;

    // normalized item handed from the axis unit on to the trig unit
    typedef struct packed {
        comp_t [2:0] vec;
        unit_t [2:0] u;
        logic        zero;
        angle_t      angle;
    } norm_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            5'd31: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/rvr_norm.sv
module rvr_norm
    import rvr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_i,
    input  in_t              data_i,
    input  logic [EPS_W-1:0] eps,
    output logic             valid_o,
    output norm_t            norm_o
);

    localparam int SQW = 2 * CW;
    localparam int QB  = UW - 1;

    typedef struct packed {
        comp_t [2:0] vec;
        comp_t [2:0] axis;
        angle_t      angle;
    } carry_t;

    carry_t carry_in;

    always_comb
    begin
        carry_in.vec   = {data_i.vec_z, data_i.vec_y, data_i.vec_x};
        carry_in.axis  = {data_i.axis_z, data_i.axis_y, data_i.axis_x};
        carry_in.angle = data_i.angle;
    end

    // squares of the axis components
    logic                  sq_valid_reg;
    logic [SQW-1:0]        sq_reg [3];
    carry_t                sq_carry_reg;
    logic signed [SQW-1:0] sq_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = SQW'($signed(carry_in.axis[i])) * SQW'($signed(carry_in.axis[i]));
        end
    end

    // square root, one result bit per stage
    logic           rt_valid_reg [0:CW];
    logic [SQW-1:0] rt_n_reg     [0:CW];
    logic [CW+1:0]  rt_rem_reg   [0:CW];
    logic [CW-1:0]  rt_root_reg  [0:CW];
    carry_t         rt_carry_reg [0:CW];

    // division, one quotient bit per stage
    logic          dv_valid_reg [0:QB];
    logic          dv_zero_reg  [0:QB];
    logic [CW-1:0] dv_len_reg   [0:QB];
    logic [CW:0]   dv_rem_reg   [0:QB][3];
    logic [QB-1:0] dv_q_reg     [0:QB][3];
    carry_t        dv_carry_reg [0:QB];

    logic          out_valid_reg;
    norm_t         out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg    <= valid_i;
            rt_valid_reg[0] <= sq_valid_reg;
            dv_valid_reg[0] <= rt_valid_reg[CW];
            out_valid_reg   <= dv_valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
            sq_carry_reg <= carry_in;

            rt_n_reg[0]     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rt_rem_reg[0]   <= '0;
            rt_root_reg[0]  <= '0;
            rt_carry_reg[0] <= sq_carry_reg;

            dv_zero_reg[0]  <= (rt_root_reg[CW] <= CW'(eps));
            dv_len_reg[0]   <= rt_root_reg[CW];
            dv_carry_reg[0] <= rt_carry_reg[CW];
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= rt_carry_reg[CW].axis[i][CW-1]
                    ? {1'b0, CW'(-rt_carry_reg[CW].axis[i])}
                    : {1'b0, rt_carry_reg[CW].axis[i]};
                dv_q_reg[0][i]   <= '0;
            end

            out_reg.vec   <= dv_carry_reg[QB].vec;
            out_reg.zero  <= dv_zero_reg[QB];
            out_reg.angle <= dv_carry_reg[QB].angle;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_zero_reg[QB])
                    out_reg.u[i] <= '0;
                else if (dv_carry_reg[QB].axis[i][CW-1])
                    out_reg.u[i] <= -$signed({1'b0, dv_q_reg[QB][i]});
                else
                    out_reg.u[i] <= $signed({1'b0, dv_q_reg[QB][i]});
            end
        end
    end

    for (genvar j = 1; j <= CW; j++)
    begin : g_sqrt
        logic [CW+3:0] rem_t;
        logic [CW+3:0] trial;
        logic          ge;

        assign rem_t = {rt_rem_reg[j-1], rt_n_reg[j-1][SQW-1 -: 2]};
        assign trial = {2'b00, rt_root_reg[j-1], 2'b01};
        assign ge    = (rem_t >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[j] <= 1'b0;
            else if (en)
                rt_valid_reg[j] <= rt_valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_n_reg[j]     <= {rt_n_reg[j-1][SQW-3:0], 2'b00};
                rt_rem_reg[j]   <= ge ? (CW+2)'(rem_t - trial) : (CW+2)'(rem_t);
                rt_root_reg[j]  <= {rt_root_reg[j-1][CW-2:0], ge};
                rt_carry_reg[j] <= rt_carry_reg[j-1];
            end
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        logic ge [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                ge[i] = (dv_rem_reg[j-1][i] >= {1'b0, dv_len_reg[j-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j] <= 1'b0;
            else if (en)
                dv_valid_reg[j] <= dv_valid_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_zero_reg[j]  <= dv_zero_reg[j-1];
                dv_len_reg[j]   <= dv_len_reg[j-1];
                dv_carry_reg[j] <= dv_carry_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (ge[i])
                        dv_rem_reg[j][i] <= {dv_rem_reg[j-1][i][CW-1:0]
                                             - dv_len_reg[j-1], 1'b0};
                    else
                        dv_rem_reg[j][i] <= {dv_rem_reg[j-1][i][CW-1:0], 1'b0};
                    dv_q_reg[j][i] <= {dv_q_reg[j-1][i][QB-2:0], ge[i]};
                end
            end
        end
    end

    assign valid_o = out_valid_reg;
    assign norm_o  = out_reg;

endmodule

FILE: rtl/rvr_cordic.sv
module rvr_cordic
    import rvr_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_i,
    input  norm_t norm_i,
    output logic  valid_o,
    output trig_t cos_o,
    output trig_t sin_o,
    output norm_t norm_o
);

    logic                 valid_reg [0:STAGES];
    logic signed [ZW-1:0] x_reg     [0:STAGES];
    logic signed [ZW-1:0] y_reg     [0:STAGES];
    logic signed [ZW-1:0] z_reg     [0:STAGES];
    logic                 neg_reg   [0:STAGES];
    norm_t                side_reg  [0:STAGES];

    logic                 out_valid_reg;
    trig_t                cos_reg;
    trig_t                sin_reg;
    norm_t                out_side_reg;

    angle_t               a_fold;
    logic                 fold_neg;
    logic signed [ZW-1:0] x_rnd;
    logic signed [ZW-1:0] y_rnd;

    // fold the angle into minus half pi to half pi, flip the sign of the result
    always_comb
    begin
        priority if (norm_i.angle > HALF_PI_Q13)
        begin
            a_fold   = norm_i.angle - PI_Q13;
            fold_neg = 1'b1;
        end
        else if (norm_i.angle < -HALF_PI_Q13)
        begin
            a_fold   = norm_i.angle + PI_Q13;
            fold_neg = 1'b1;
        end
        else
        begin
            a_fold   = norm_i.angle;
            fold_neg = 1'b0;
        end
    end

    assign x_rnd = (x_reg[STAGES] + ZW'(8192)) >>> 14;
    assign y_rnd = (y_reg[STAGES] + ZW'(8192)) >>> 14;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0]  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0]  <= valid_i;
            out_valid_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= ZW'(a_fold) <<< 17;
            neg_reg[0]  <= fold_neg;
            side_reg[0] <= norm_i;

            cos_reg      <= neg_reg[STAGES] ? TW'(-x_rnd) : TW'(x_rnd);
            sin_reg      <= neg_reg[STAGES] ? TW'(-y_rnd) : TW'(y_rnd);
            out_side_reg <= side_reg[STAGES];
        end
    end

    for (genvar i = 1; i <= STAGES; i++)
    begin : g_stage
        logic signed [ZW-1:0] xs;
        logic signed [ZW-1:0] ys;
        logic signed [ZW-1:0] at;

        assign xs = x_reg[i-1] >>> (i - 1);
        assign ys = y_reg[i-1] >>> (i - 1);
        assign at = atan_q30(5'(i - 1));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= valid_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i-1][ZW-1])
                begin
                    x_reg[i] <= x_reg[i-1] - ys;
                    y_reg[i] <= y_reg[i-1] + xs;
                    z_reg[i] <= z_reg[i-1] - at;
                end
                else
                begin
                    x_reg[i] <= x_reg[i-1] + ys;
                    y_reg[i] <= y_reg[i-1] - xs;
                    z_reg[i] <= z_reg[i-1] + at;
                end
                neg_reg[i]  <= neg_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign valid_o = out_valid_reg;
    assign cos_o   = cos_reg;
    assign sin_o   = sin_reg;
    assign norm_o  = out_side_reg;

endmodule

FILE: rtl/rodrigues_vector_rotation.sv
// Rodrigues rotation of a Q4.12 vector about an arbitrary Q4.12 axis by a Q3.13 angle.
// The pipeline accepts one transaction per clock while the output is not held, and delivers
// one result per transaction, in order. Its stages are the axis length (squares, sum and a
// one-bit-per-stage square root), the three parallel dividers that normalize the axis,
// sine and cosine by CORDIC, and the products and the final sum.
// The whole pipeline holds while a result waits at the output, so in_ready is low
// exactly then. Axes whose length is at or below the epsilon set through cfg_data give
// v*cos and set axis_was_zero; clipped components set saturated.
module rodrigues_vector_rotation
    import rvr_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_data
);

    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic             en;
    logic [EPS_W-1:0] eps_reg;

    logic             nm_valid;
    norm_t            nm;
    logic             cd_valid;
    trig_t            cd_cos;
    trig_t            cd_sin;
    norm_t            cd_side;

    // stage 1: products
    logic               f1_valid_reg;
    logic signed [33:0] f1_p_reg  [3][3];
    logic signed [33:0] f1_t1_reg [3];
    logic signed [18:0] f1_omc_reg;
    trig_t              f1_sin_reg;
    unit_t [2:0]        f1_u_reg;
    logic               f1_zero_reg;

    // stage 2: dot and cross
    logic               f2_valid_reg;
    logic signed [19:0] f2_d_reg;
    logic signed [18:0] f2_w_reg  [3];
    logic signed [33:0] f2_t1_reg [3];
    logic signed [18:0] f2_omc_reg;
    trig_t              f2_sin_reg;
    unit_t [2:0]        f2_u_reg;
    logic               f2_zero_reg;

    // stage 3
    logic               f3_valid_reg;
    logic signed [37:0] f3_ud_reg [3];
    logic signed [36:0] f3_t2_reg [3];
    logic signed [33:0] f3_t1_reg [3];
    logic signed [18:0] f3_omc_reg;
    logic               f3_zero_reg;

    // stage 4
    logic               f4_valid_reg;
    logic signed [40:0] f4_t3_reg [3];
    logic signed [36:0] f4_t2_reg [3];
    logic signed [33:0] f4_t1_reg [3];
    logic               f4_zero_reg;

    // output register
    logic               out_valid_reg;
    out_t               out_reg;

    logic signed [35:0] dot_c;
    logic signed [34:0] cross_c [3];
    logic signed [21:0] r1_c    [3];
    logic signed [42:0] acc_c   [3];
    logic signed [26:0] r_c     [3];
    comp_t              rot_c   [3];
    logic [2:0]         clip_c;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_data;
    end

    rvr_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (in_valid),
        .data_i  (in_data),
        .eps     (eps_reg),
        .valid_o (nm_valid),
        .norm_o  (nm)
    );

    rvr_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (nm_valid),
        .norm_i  (nm),
        .valid_o (cd_valid),
        .cos_o   (cd_cos),
        .sin_o   (cd_sin),
        .norm_o  (cd_side)
    );

    always_comb
    begin
        dot_c      = 36'(f1_p_reg[0][0]) + 36'(f1_p_reg[1][1]) + 36'(f1_p_reg[2][2]);
        cross_c[0] = 35'(f1_p_reg[1][2]) - 35'(f1_p_reg[2][1]);
        cross_c[1] = 35'(f1_p_reg[2][0]) - 35'(f1_p_reg[0][2]);
        cross_c[2] = 35'(f1_p_reg[0][1]) - 35'(f1_p_reg[1][0]);
        for (int i = 0; i < 3; i++)
        begin
            r1_c[i]  = 22'((f3_ud_reg[i] + 38'sd32768) >>> 16);
            acc_c[i] = 43'(f4_t1_reg[i]) + 43'(f4_t2_reg[i]) + 43'(f4_t3_reg[i]);
            r_c[i]   = 27'((acc_c[i] + 43'sd32768) >>> 16);
            priority if (r_c[i] > 27'(MAXV))
            begin
                rot_c[i]  = MAXV;
                clip_c[i] = 1'b1;
            end
            else if (r_c[i] < 27'(MINV))
            begin
                rot_c[i]  = MINV;
                clip_c[i] = 1'b1;
            end
            else
            begin
                rot_c[i]  = CW'(r_c[i]);
                clip_c[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            f4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg  <= cd_valid;
            f2_valid_reg  <= f1_valid_reg;
            f3_valid_reg  <= f2_valid_reg;
            f4_valid_reg  <= f3_valid_reg;
            out_valid_reg <= f4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    f1_p_reg[i][j] <= 34'($signed(cd_side.u[i])) * 34'($signed(cd_side.vec[j]));
                end
                f1_t1_reg[i] <= 34'($signed(cd_side.vec[i])) * 34'(cd_cos);
            end
            f1_omc_reg  <= 19'sd65536 - 19'(cd_cos);
            f1_sin_reg  <= cd_sin;
            f1_u_reg    <= cd_side.u;
            f1_zero_reg <= cd_side.zero;

            f2_d_reg <= 20'((dot_c + 36'sd32768) >>> 16);
            for (int i = 0; i < 3; i++)
            begin
                f2_w_reg[i]  <= 19'((cross_c[i] + 35'sd32768) >>> 16);
                f2_t1_reg[i] <= f1_t1_reg[i];
            end
            f2_omc_reg  <= f1_omc_reg;
            f2_sin_reg  <= f1_sin_reg;
            f2_u_reg    <= f1_u_reg;
            f2_zero_reg <= f1_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                f3_ud_reg[i] <= 38'($signed(f2_u_reg[i])) * 38'(f2_d_reg);
                f3_t2_reg[i] <= 37'(f2_w_reg[i]) * 37'(f2_sin_reg);
                f3_t1_reg[i] <= f2_t1_reg[i];
            end
            f3_omc_reg  <= f2_omc_reg;
            f3_zero_reg <= f2_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                f4_t3_reg[i] <= 41'(r1_c[i]) * 41'(f3_omc_reg);
                f4_t2_reg[i] <= f3_t2_reg[i];
                f4_t1_reg[i] <= f3_t1_reg[i];
            end
            f4_zero_reg <= f3_zero_reg;

            out_reg.rot_x         <= rot_c[0];
            out_reg.rot_y         <= rot_c[1];
            out_reg.rot_z         <= rot_c[2];
            out_reg.axis_was_zero <= f4_zero_reg;
            out_reg.saturated     <= |clip_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a held result freezes the whole pipeline, input included
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while a result is held");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.rot_x == MAXV || out_data.rot_x == MINV ||
             out_data.rot_y == MAXV || out_data.rot_y == MINV ||
             out_data.rot_z == MAXV || out_data.rot_z == MINV))
        else $error("saturated flag without a clipped component");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        cd_valid |-> (cd_cos <= 18'sd65600 && cd_cos >= -18'sd65600 &&
                      cd_sin <= 18'sd65600 && cd_sin >= -18'sd65600))
        else $error("sine or cosine out of range");

endmodule
